// File: src/ptdps_pkg.sv
package ptdps_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    K_PUSH_FRONT = 4'd0,
    K_PUSH_BACK  = 4'd1,
    K_POP_FRONT  = 4'd2,
    K_POP_BACK   = 4'd3,
    K_PEEK_FRONT = 4'd4,
    K_PEEK_BACK  = 4'd5,
    K_REMOVE     = 4'd6,
    K_MAX_PRIO   = 4'd7,
    K_MIN_PRIO   = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_SHR,
    CM_DEL,
    CM_LOAD,
    CM_ROT
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } entry_t;

endpackage

// File: src/ptdps_cell.sv
module ptdps_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  ptdps_pkg::cell_mode_t  mode,
  input  logic [IW-1:0]          pos,
  input  ptdps_pkg::entry_t      left,
  input  ptdps_pkg::entry_t      right,
  input  ptdps_pkg::entry_t      load,
  output ptdps_pkg::entry_t      data
);
  import ptdps_pkg::*;

  localparam logic [IW-1:0] MY = IW'(IDX);

  always_ff @(posedge clk) begin
    case (mode)
      CM_SHR: data <= left;
      CM_ROT: data <= right;
      CM_DEL: begin
        if (MY >= pos) data <= right;
      end
      CM_LOAD: begin
        if (MY == pos) data <= load;
      end
      default: data <= data;
    endcase
  end

endmodule

// File: src/process_table_deque_priority_search.sv
// Ordered table of up to DEPTH entries (16-bit id, 8-bit priority) kept in a row of cells,
// front in cell 0. An item is accepted when start is high and busy is low; its result
// appears on out_id, out_priority, status and entry_count with done high for exactly one
// cycle, and must be taken then since it cannot be held off. Push front, push back, pop
// front, peek front, and any item answered from the count alone (full table, empty table,
// unused kind) give a registered result in the cycle after the item, and busy stays
// low, so the next item can follow at once. Pop back, peek back, remove by id and the
// max/min priority searches rotate the whole cell ring once past cell 0 while scanning,
// then pass through a finishing state: busy stays high through both, the result is
// registered in the finishing state, and the next item is taken in the cycle the result
// appears at the earliest. After reset the table is empty.
module process_table_deque_priority_search #(
  parameter int DEPTH = ptdps_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind,
  input  logic [15:0] proc_id,
  input  logic [7:0]  proc_priority,
  output logic        done,
  output logic [15:0] out_id,
  output logic [7:0]  out_priority,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);
  import ptdps_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [IW-1:0]   t, t_next;
  logic [IW-1:0]   m, m_next;
  logic            found, found_next;
  kind_t           kind_r, kind_next;
  logic [15:0]     id_r, id_next;
  entry_t          best, best_next;
  logic            done_next;
  logic [15:0]     out_id_next;
  logic [7:0]      out_priority_next;
  status_t         status_r, status_next;
  logic [4:0]      entry_count_next;

  cell_mode_t      cmode;
  logic [IW-1:0]   cpos;
  entry_t          new_entry;
  entry_t          cell_q [DEPTH];
  entry_t          cur;
  logic            accept;
  logic            scan_req;
  logic            in_range;

  assign accept    = start && !busy;
  assign new_entry = '{id: proc_id, prio: proc_priority};
  assign cur       = cell_q[0];
  assign in_range  = CW'(t) < count;
  assign scan_req  = accept && (count != '0) &&
                     (kind_t'(kind) inside {K_POP_BACK, K_PEEK_BACK, K_REMOVE,
                                            K_MAX_PRIO, K_MIN_PRIO});

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    ptdps_cell #(
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .mode  (cmode),
      .pos   (cpos),
      .left  ((k == 0) ? new_entry : cell_q[(k + DEPTH - 1) % DEPTH]),
      .right (cell_q[(k + 1) % DEPTH]),
      .load  (new_entry),
      .data  (cell_q[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (scan_req) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (t == IW'(DEPTH - 1)) state_next = S_FIN;
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    cmode             = CM_HOLD;
    cpos              = '0;
    count_next        = count;
    t_next            = t;
    m_next            = m;
    found_next        = found;
    kind_next         = kind_r;
    id_next           = id_r;
    best_next         = best;
    done_next         = 1'b0;
    out_id_next       = out_id;
    out_priority_next = out_priority;
    status_next       = status_r;
    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_next         = kind_t'(kind);
          id_next           = proc_id;
          found_next        = 1'b0;
          t_next            = '0;
          out_id_next       = '0;
          out_priority_next = '0;
          status_next       = ST_NONE;
          done_next         = !scan_req;
          case (kind_t'(kind))
            K_PUSH_FRONT, K_PUSH_BACK: begin
              if (count == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                cmode             = (kind_t'(kind) == K_PUSH_FRONT) ? CM_SHR : CM_LOAD;
                cpos              = count[IW-1:0];
                count_next        = count + CW'(1);
                out_id_next       = proc_id;
                out_priority_next = proc_priority;
                status_next       = ST_OK;
              end
            end
            K_POP_FRONT, K_PEEK_FRONT: begin
              if (count != '0) begin
                out_id_next       = cur.id;
                out_priority_next = cur.prio;
                status_next       = ST_OK;
                if (kind_t'(kind) == K_POP_FRONT) begin
                  cmode      = CM_DEL;
                  cpos       = '0;
                  count_next = count - CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmode  = CM_ROT;
        t_next = t + IW'(1);
        case (kind_r)
          K_POP_BACK, K_PEEK_BACK: begin
            if (CW'(t) + CW'(1) == count) begin
              best_next  = cur;
              found_next = 1'b1;
            end
          end
          K_REMOVE: begin
            if (in_range && !found && cur.id == id_r) begin
              best_next  = cur;
              found_next = 1'b1;
              m_next     = t;
            end
          end
          K_MAX_PRIO: begin
            if (t == '0 || (in_range && cur.prio > best.prio)) begin
              best_next  = cur;
              found_next = 1'b1;
            end
          end
          K_MIN_PRIO: begin
            if (t == '0 || (in_range && cur.prio < best.prio)) begin
              best_next  = cur;
              found_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        done_next = 1'b1;
        if (found) begin
          out_id_next       = best.id;
          out_priority_next = best.prio;
          status_next       = ST_OK;
          if (kind_r == K_POP_BACK) begin
            count_next = count - CW'(1);
          end else if (kind_r == K_REMOVE) begin
            cmode      = CM_DEL;
            cpos       = m;
            count_next = count - CW'(1);
          end
        end else begin
          out_id_next       = '0;
          out_priority_next = '0;
          status_next       = ST_NONE;
        end
      end
      default: ;
    endcase
    entry_count_next = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    t            <= t_next;
    m            <= m_next;
    found        <= found_next;
    kind_r       <= kind_next;
    id_r         <= id_next;
    best         <= best_next;
    out_id       <= out_id_next;
    out_priority <= out_priority_next;
    status_r     <= status_next;
    entry_count  <= entry_count_next;
  end

  assign busy   = (state != S_IDLE);
  assign status = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) || (count == $past(count) + CW'(1)) ||
                    (count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && count == CW'(DEPTH) && (kind == K_PUSH_FRONT || kind == K_PUSH_BACK))
    |=> done && status == ST_FULL && out_id == '0)
    else $error("push into full table not flagged");

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !done)
    else $error("result strobe during ring walk");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> done && !busy)
    else $error("walk finish did not deliver a result");

endmodule
